// File: hdl/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int UNIT_SHIFT = 3;
  localparam int UNIT_BYTES = 1 << UNIT_SHIFT;
  localparam int NUM_UNITS  = PAGE_BYTES / UNIT_BYTES;
  localparam int IDX_W      = $clog2(NUM_UNITS);
  localparam int LEN_W      = $clog2(NUM_UNITS + 1);
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 13;
  localparam int NEED_W     = SIZE_W - UNIT_SHIFT;
  localparam int DATA_W     = 64;
  localparam int PADDR_W    = 3;

  localparam logic [PADDR_W-1:0] REG_BASE_ADDRESS = '0;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;
  } alloc_req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_address;
  } alloc_rsp_t;

  typedef struct packed {
    logic used;
    logic start;
  } unit_t;

  typedef struct packed {
    logic  shift;
    unit_t tail;
  } ring_ctl_t;

endpackage
`default_nettype wire

// File: hdl/first_fit_page_allocator.sv
// First-fit allocator for one page of 4096 bytes in 512 units of 8 bytes. An
// operation is taken when start is high and busy is low, and its single result
// beat appears on result for exactly one cycle with result_valid high; it cannot
// be held off, so the receiver must take it then. The occupancy and block-start
// bits live in a ring of 512 cells that rotates past the sequencer one unit per
// cycle in S_SCAN, S_COMMIT and S_FREE. A bad size, an oversized request or a
// misaligned or out-of-page address answers in the cycle after acceptance, a free
// after S_PREP and a rotation, an allocate with no space after a rotation, and a
// successful one after a rotation to search and one to mark. Reset clears the
// ring, so the block is usable at once. The user must write base_address over
// the config port only while the block is idle; the block does not enforce it.
`default_nettype none
module first_fit_page_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire ffpa_pkg::alloc_req_t            request,
  output      logic                            result_valid,
  output      ffpa_pkg::alloc_rsp_t            result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ffpa_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [ffpa_pkg::DATA_W-1:0]     pwdata,
  output      logic [ffpa_pkg::DATA_W-1:0]     prdata,
  output      logic                            pready
);

  logic [ffpa_pkg::ADDR_W-1:0] base_address;
  ffpa_pkg::unit_t             units [ffpa_pkg::NUM_UNITS];
  ffpa_pkg::ring_ctl_t         ring;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ffpa_pkg::REG_BASE_ADDRESS) begin
      base_address <= pwdata[ffpa_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ffpa_pkg::REG_BASE_ADDRESS) begin
      prdata = ffpa_pkg::DATA_W'(base_address);
    end
  end

  for (genvar i = 0; i < ffpa_pkg::NUM_UNITS; i++) begin : g_ring
    if (i == ffpa_pkg::NUM_UNITS - 1) begin : g_tail
      ffpa_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring.shift),
        .d     (ring.tail),
        .q     (units[i])
      );
    end else begin : g_body
      ffpa_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring.shift),
        .d     (units[i+1]),
        .q     (units[i])
      );
    end
  end

  ffpa_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .base         (base_address),
    .head         (units[0]),
    .ring         (ring),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

// File: hdl/ffpa_cell.sv
`default_nettype none
module ffpa_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           shift,
  input  wire ffpa_pkg::unit_t d,
  output      ffpa_pkg::unit_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ffpa_seq.sv
`default_nettype none
module ffpa_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire ffpa_pkg::alloc_req_t           request,
  input  wire logic [ffpa_pkg::ADDR_W-1:0]    base,
  input  wire ffpa_pkg::unit_t                head,
  output      ffpa_pkg::ring_ctl_t            ring,
  output      logic                           result_valid,
  output      ffpa_pkg::alloc_rsp_t           result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_COMMIT,
    S_FREE
  } state_t;

  state_t                          state;
  logic [ffpa_pkg::IDX_W-1:0]      cnt;
  logic [ffpa_pkg::LEN_W-1:0]      run;
  logic [ffpa_pkg::LEN_W-1:0]      need;
  logic [ffpa_pkg::IDX_W-1:0]      first;
  logic                            found;
  logic                            hit;
  logic [ffpa_pkg::LEN_W-1:0]      len;
  logic [ffpa_pkg::LEN_W-1:0]      block_units [ffpa_pkg::NUM_UNITS];

  logic [ffpa_pkg::NEED_W-1:0]     need_full;
  logic                            size_ok;
  logic                            fits;
  logic [ffpa_pkg::ADDR_W-1:0]     off;
  logic                            off_ok;
  logic [ffpa_pkg::IDX_W-1:0]      off_first;
  logic [ffpa_pkg::LEN_W-1:0]      run_inc;
  logic                            hit_run;
  logic [ffpa_pkg::IDX_W-1:0]      found_first;
  logic                            last;
  logic [ffpa_pkg::LEN_W-1:0]      span;
  logic                            past_first;
  logic                            at_first;
  logic                            in_blk;
  logic                            hit_now;
  logic                            clear;
  logic [ffpa_pkg::ADDR_W-1:0]     alloc_addr;

  assign busy = (state != S_IDLE);

  assign need_full = request.size_bytes[ffpa_pkg::SIZE_W-1:ffpa_pkg::UNIT_SHIFT];
  assign size_ok   = (request.size_bytes != '0) &&
                     (request.size_bytes[ffpa_pkg::UNIT_SHIFT-1:0] == '0);
  assign fits      = (need_full <= ffpa_pkg::NEED_W'(ffpa_pkg::NUM_UNITS));

  assign off       = request.address - base;
  assign off_ok    = (off < ffpa_pkg::ADDR_W'(ffpa_pkg::PAGE_BYTES)) &&
                     (off[ffpa_pkg::UNIT_SHIFT-1:0] == '0);
  assign off_first = off[ffpa_pkg::UNIT_SHIFT +: ffpa_pkg::IDX_W];

  assign run_inc     = run + ffpa_pkg::LEN_W'(1);
  assign hit_run     = !found && !head.used && (run_inc == need);
  assign found_first = cnt - ffpa_pkg::IDX_W'(need - ffpa_pkg::LEN_W'(1));
  assign last        = (cnt == ffpa_pkg::IDX_W'(ffpa_pkg::NUM_UNITS - 1));

  assign past_first = (cnt >= first);
  assign at_first   = (cnt == first);
  assign span       = ffpa_pkg::LEN_W'(cnt - first);
  assign in_blk     = past_first && (span < need);
  assign hit_now    = hit || (at_first && head.start);
  assign clear      = hit_now && past_first && (span < len);

  assign alloc_addr = base + (ffpa_pkg::ADDR_W'(first) << ffpa_pkg::UNIT_SHIFT);

  always_comb begin
    ring.shift = 1'b0;
    ring.tail  = head;
    case (state)
      S_SCAN: begin
        ring.shift = 1'b1;
      end
      S_COMMIT: begin
        ring.shift      = 1'b1;
        ring.tail.used  = head.used | in_blk;
        ring.tail.start = head.start | at_first;
      end
      S_FREE: begin
        ring.shift      = 1'b1;
        ring.tail.used  = head.used & ~clear;
        ring.tail.start = head.start & ~at_first;
      end
      default: begin
        ring.shift = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    len <= block_units[first];
    if (state == S_SCAN && last && !found && hit_run) begin
      block_units[found_first] <= need;
    end else if (state == S_SCAN && last && found) begin
      block_units[first] <= need;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cnt                  <= '0;
            result.block_address <= '0;
            if (request.mode == ffpa_pkg::MODE_ALLOC) begin
              if (!size_ok) begin
                result_valid  <= 1'b1;
                result.status <= ffpa_pkg::ST_BAD_SIZE;
              end else if (!fits) begin
                result_valid  <= 1'b1;
                result.status <= ffpa_pkg::ST_NO_SPACE;
              end else begin
                need  <= ffpa_pkg::LEN_W'(need_full);
                run   <= '0;
                found <= 1'b0;
                state <= S_SCAN;
              end
            end else begin
              if (!off_ok) begin
                result_valid  <= 1'b1;
                result.status <= ffpa_pkg::ST_BAD_ADDR;
              end else begin
                first <= off_first;
                hit   <= 1'b0;
                state <= S_PREP;
              end
            end
          end
        end
        S_PREP: begin
          state <= S_FREE;
        end
        S_SCAN: begin
          cnt <= cnt + ffpa_pkg::IDX_W'(1);
          run <= head.used ? '0 : run_inc;
          if (hit_run) begin
            found <= 1'b1;
            first <= found_first;
          end
          if (last) begin
            if (found || hit_run) begin
              state <= S_COMMIT;
            end else begin
              state                <= S_IDLE;
              result_valid         <= 1'b1;
              result.status        <= ffpa_pkg::ST_NO_SPACE;
              result.block_address <= '0;
            end
          end
        end
        S_COMMIT: begin
          cnt <= cnt + ffpa_pkg::IDX_W'(1);
          if (last) begin
            state                <= S_IDLE;
            result_valid         <= 1'b1;
            result.status        <= ffpa_pkg::ST_OK;
            result.block_address <= alloc_addr;
          end
        end
        S_FREE: begin
          cnt <= cnt + ffpa_pkg::IDX_W'(1);
          hit <= hit_now;
          if (last) begin
            state                <= S_IDLE;
            result_valid         <= 1'b1;
            result.status        <= hit_now ? ffpa_pkg::ST_OK : ffpa_pkg::ST_BAD_ADDR;
            result.block_address <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ffpa_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int SETTLE_CYCLES = 1100;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  alloc_req_t request = '0;
  logic result_valid;
  alloc_rsp_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  first_fit_page_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bit unit_taken [NUM_UNITS];
  bit block_head [NUM_UNITS];
  int head_len [NUM_UNITS];
  logic [ADDR_W-1:0] page_base = '0;

  alloc_req_t pending_ops [$];
  alloc_rsp_t rsp_due [$];
  int issued_cnt = 0;
  int taken_cnt = 0;
  int gap_left = 0;
  bit gaps_on = 1'b1;
  int errors = 0;
  int cycles = 0;

  function automatic alloc_rsp_t alloc_outcome(alloc_req_t op);
    alloc_rsp_t rsp;
    logic [ADDR_W-1:0] off;
    int need;
    int run;
    int first;
    rsp.status = ST_OK;
    rsp.block_address = '0;
    if (op.mode == MODE_ALLOC) begin
      if (op.size_bytes == 0 || (op.size_bytes % UNIT_BYTES) != 0) begin
        rsp.status = ST_BAD_SIZE;
        return rsp;
      end
      rsp.status = ST_NO_SPACE;
      need = op.size_bytes / UNIT_BYTES;
      if (need > NUM_UNITS) return rsp;
      run = 0;
      for (int u = 0; u < NUM_UNITS; u++) begin
        if (unit_taken[u]) begin
          run = 0;
        end else begin
          run++;
          if (run == need) begin
            first = u + 1 - run;
            for (int k = first; k <= u; k++) unit_taken[k] = 1'b1;
            block_head[first] = 1'b1;
            head_len[first] = run;
            rsp.status = ST_OK;
            rsp.block_address = page_base + ADDR_W'(first * UNIT_BYTES);
            return rsp;
          end
        end
      end
      return rsp;
    end
    off = op.address - page_base;
    if (off >= PAGE_BYTES || (off % UNIT_BYTES) != 0) begin
      rsp.status = ST_BAD_ADDR;
      return rsp;
    end
    first = int'(off / UNIT_BYTES);
    if (!block_head[first]) begin
      rsp.status = ST_BAD_ADDR;
      return rsp;
    end
    for (int k = 0; k < head_len[first] && first + k < NUM_UNITS; k++)
      unit_taken[first + k] = 1'b0;
    block_head[first] = 1'b0;
    head_len[first] = 0;
    return rsp;
  endfunction

  // Driver: a beat is offered at the falling edge and held until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && taken_cnt != issued_cnt) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_ops.size() > 0) begin
      if (gaps_on && $urandom_range(0, 9) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 5);
      end else begin
        request <= pending_ops.pop_front();
        start <= 1'b1;
        issued_cnt <= issued_cnt + 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      rsp_due.push_back(alloc_outcome(request));
      taken_cnt <= taken_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (psel && penable && pwrite && pready && paddr == REG_BASE_ADDRESS)
      page_base <= pwdata[ADDR_W-1:0];
  end

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst && result_valid) begin
      if (rsp_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: status %0d addr %h",
                   result.status, result.block_address);
      end else begin
        want = rsp_due.pop_front();
        if (result.status !== want.status || result.block_address !== want.block_address) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status %0d addr %h, got status %0d addr %h",
                     want.status, want.block_address, result.status, result.block_address);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  task automatic push_op(logic mode, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    alloc_req_t op;
    op.mode = mode;
    op.size_bytes = (mode == MODE_ALLOC) ? size : SIZE_W'($urandom_range(0, PAGE_BYTES));
    op.address = (mode == MODE_FREE) ? addr : rand_addr();
    pending_ops.push_back(op);
  endtask

  task automatic idle_wait();
    while (pending_ops.size() > 0 || start || rsp_due.size() > 0 || busy)
      @(posedge clk);
  endtask

  task automatic cfg_write(logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_BASE_ADDRESS;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return SIZE_W'(UNIT_BYTES * $urandom_range(1, 16));
    if (r == 7) return SIZE_W'(UNIT_BYTES * $urandom_range(1, NUM_UNITS));
    if (r == 8) return SIZE_W'($urandom_range(0, PAGE_BYTES));
    case ($urandom_range(0, 2))
      0: return '0;
      1: return SIZE_W'(PAGE_BYTES);
      default: return SIZE_W'(UNIT_BYTES * $urandom_range(1, NUM_UNITS) - $urandom_range(1, 7));
    endcase
  endfunction

  task automatic make_batch(int n);
    int heads [$];
    int roll;
    logic [ADDR_W-1:0] ad;
    for (int u = 0; u < NUM_UNITS; u++)
      if (block_head[u]) heads.push_back(u);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45 || (roll < 85 && heads.size() == 0)) begin
        push_op(MODE_ALLOC, pick_size(), '0);
      end else if (roll < 85) begin
        ad = page_base + ADDR_W'(heads[$urandom_range(0, heads.size() - 1)] * UNIT_BYTES);
        push_op(MODE_FREE, '0, ad);
      end else begin
        case ($urandom_range(0, 3))
          0: ad = rand_addr();
          1: ad = page_base + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
          2: ad = page_base + ADDR_W'(PAGE_BYTES + $urandom_range(0, 64));
          default: ad = page_base - ADDR_W'(UNIT_BYTES * $urandom_range(1, 4));
        endcase
        push_op(MODE_FREE, '0, ad);
      end
    end
  endtask

  task automatic run_random(int n);
    int done;
    int k;
    done = 0;
    while (done < n) begin
      k = $urandom_range(1, 10);
      if (k > n - done) k = n - done;
      make_batch(k);
      idle_wait();
      done += k;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Base left at its reset value: size checks, a full page and hole reuse.
    push_op(MODE_ALLOC, 13'd0, '0);
    push_op(MODE_ALLOC, 13'd4095, '0);
    push_op(MODE_ALLOC, 13'd7, '0);
    push_op(MODE_ALLOC, SIZE_W'(PAGE_BYTES), '0);
    push_op(MODE_ALLOC, 13'd8, '0);
    push_op(MODE_FREE, '0, 48'd8);
    push_op(MODE_FREE, '0, 48'd4);
    push_op(MODE_FREE, '0, ADDR_W'(PAGE_BYTES));
    push_op(MODE_FREE, '0, ADDR_TOP - 48'd7);
    push_op(MODE_FREE, '0, 48'd0);
    push_op(MODE_FREE, '0, 48'd0);
    push_op(MODE_ALLOC, 13'd8, '0);
    push_op(MODE_ALLOC, 13'd16, '0);
    push_op(MODE_ALLOC, 13'd8, '0);
    push_op(MODE_FREE, '0, 48'd8);
    push_op(MODE_ALLOC, 13'd24, '0);
    push_op(MODE_ALLOC, 13'd16, '0);
    push_op(MODE_FREE, '0, rand_addr());
    idle_wait();

    // Base at the top of the address space, so offsets wrap past zero.
    cfg_write({16'hA5C3, ADDR_TOP});
    push_op(MODE_ALLOC, 13'd8, '0);
    push_op(MODE_FREE, '0, ADDR_TOP);
    push_op(MODE_ALLOC, 13'd16, '0);
    push_op(MODE_ALLOC, 13'd8, '0);
    push_op(MODE_FREE, '0, 48'd15);
    push_op(MODE_FREE, '0, ADDR_TOP);
    idle_wait();

    cfg_write({$urandom, $urandom});
    run_random(380);

    cfg_write({16'($urandom), ADDR_TOP - 48'd2047 + ADDR_W'($urandom_range(0, 15))});
    run_random(380);

    cfg_write('0);
    run_random(250);

    gaps_on = 1'b0;
    make_batch(150);
    idle_wait();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rsp_due.size() != 0) errors++;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ffpa_pkg.sv
hdl/ffpa_cell.sv
hdl/ffpa_seq.sv
hdl/first_fit_page_allocator.sv
bench/testbench.sv
